>>> src/lower_median_abs_deviation_sum_defines.svh
// Assertion macros shared by the RTL.
`ifndef LOWER_MEDIAN_ABS_DEVIATION_SUM_DEFINES_SVH
`define LOWER_MEDIAN_ABS_DEVIATION_SUM_DEFINES_SVH

`ifndef ASSERT_OFF
`define LMADS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LMADS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define LMADS_ASSERT(lbl, clk, rst_n, prop)
`define LMADS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> src/lmads_pkg.sv
`default_nettype none

package lmads_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int POS_W          = 32;
    localparam int TOTAL_W        = 42;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]   median;
        logic [TOTAL_W-1:0] total_distance;
        logic               overflowed;
    } t_out;

    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] val;
    } t_slot;

endpackage

`default_nettype wire

>>> src/lower_median_abs_deviation_sum.sv
// Lower median and absolute deviation sum over a set of positions.
// Input beats carry a 32-bit position and a last flag. Positions are taken
// one per cycle, when not stalled, into a row of sorting cells; beats beyond
// the row's depth are dropped and reported through the overflowed flag of the
// result. The beat with last set closes the set. The block then stalls its
// input while the row settles and is shifted out, smallest value first. A
// running sum picks up the median on the way and the finish state forms the
// total. The next set is taken as soon as the result is loaded. The result
// sits in an output register; while the receiver stalls it, the block keeps
// loading the next set and only waits before loading a second result. Reset
// empties the row, clears the count and the overflow flag and drops any
// pending result.
`default_nettype none
`include "lower_median_abs_deviation_sum_defines.svh"

module lower_median_abs_deviation_sum #(
    parameter int MAX_POINTS = lmads_pkg::MAX_POINTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lmads_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lmads_pkg::t_out    o_out_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = CNT_W + lmads_pkg::POS_W + 1;
    localparam int EXT_W = (SUM_W > lmads_pkg::TOTAL_W + 1) ? SUM_W : lmads_pkg::TOTAL_W + 1;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SETTLE = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;

    logic [2:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_tick, n_tick;
    logic                         r_ovf, n_ovf;
    logic signed [SUM_W-1:0]      r_acc, n_acc;
    logic [lmads_pkg::POS_W-1:0]  r_med, n_med;
    logic                         r_out_vld, n_out_vld;
    lmads_pkg::t_out              r_out, n_out;

    lmads_pkg::t_slot             w_ins;
    lmads_pkg::t_slot             w_head;
    logic                         w_spill;
    logic                         w_drain;
    logic                         w_finish;
    logic                         w_out_take;
    logic                         w_in_acc;
    logic                         w_room;
    logic [CNT_W-1:0]             w_k;
    logic signed [SUM_W-1:0]      w_x;
    logic signed [SUM_W-1:0]      w_total;
    logic [EXT_W-1:0]             w_ext;

    assign o_in_stall = (r_state != ST_LOAD);
    assign w_in_acc   = i_in_valid && (r_state == ST_LOAD);
    assign w_room     = (r_count < CNT_W'(MAX_POINTS));
    assign w_drain    = (r_state == ST_DRAIN);
    assign w_finish   = (r_state == ST_FINISH);
    assign w_out_take = r_out_vld && !i_out_stall;
    assign w_ins      = {w_in_acc && w_room, i_in_data.position};

    lmads_chain #(
        .MAX_POINTS (MAX_POINTS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_drain (w_drain),
        .i_ins   (w_ins),
        .o_head  (w_head),
        .o_spill (w_spill)
    );

    assign w_k     = CNT_W'((r_count - CNT_W'(1)) >> 1);
    assign w_x     = $signed(SUM_W'(w_head.val));
    // With an even count the median has one more element above it than below.
    assign w_total = r_acc - (r_count[0] ? SUM_W'(0) : $signed(SUM_W'(r_med)));
    assign w_ext   = EXT_W'($unsigned(w_total));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_tick    = r_tick;
        n_ovf     = r_ovf;
        n_acc     = r_acc;
        n_med     = r_med;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        n_state = ST_SETTLE;
                        n_tick  = '0;
                    end
                end
            end
            ST_SETTLE: begin
                n_tick = r_tick + CNT_W'(1);
                if (r_tick == r_count) begin
                    n_state = ST_DRAIN;
                    n_tick  = '0;
                    n_acc   = '0;
                end
            end
            ST_DRAIN: begin
                n_tick = r_tick + CNT_W'(1);
                if (r_tick < w_k) begin
                    n_acc = r_acc - w_x;
                end else if (r_tick == w_k) begin
                    n_med = w_head.val;
                end else begin
                    n_acc = r_acc + w_x;
                end
                if (r_tick == r_count - CNT_W'(1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.median         = r_med;
                    n_out.total_distance = (|w_ext[EXT_W-1:lmads_pkg::TOTAL_W])
                                           ? '1 : w_ext[lmads_pkg::TOTAL_W-1:0];
                    n_out.overflowed     = r_ovf;
                    n_out_vld            = 1'b1;
                    n_count              = '0;
                    n_ovf                = 1'b0;
                    n_state              = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_tick    <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_tick    <= n_tick;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_med <= n_med;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `LMADS_NEVER(a_no_spill, i_clk, i_rst_n, w_spill)
    `LMADS_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(MAX_POINTS))
    `LMADS_ASSERT(a_head_valid, i_clk, i_rst_n, w_drain |-> w_head.vld)
    `LMADS_NEVER(a_drain_sorted, i_clk, i_rst_n, w_drain && $past(w_drain) && (w_head.val < $past(w_head.val)))
    `LMADS_ASSERT(a_result_taken, i_clk, i_rst_n, (w_out_take && !w_finish) |=> !r_out_vld)

endmodule

`default_nettype wire

>>> src/lmads_cell.sv
`default_nettype none

module lmads_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_drain,
    input  wire lmads_pkg::t_slot i_ins,
    input  wire lmads_pkg::t_slot i_nbr,
    output lmads_pkg::t_slot     o_hold,
    output lmads_pkg::t_slot     o_pass
);

    lmads_pkg::t_slot r_hold;
    lmads_pkg::t_slot r_pass;

    // Keeps the smaller value and passes the larger right; drain shifts left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.vld <= 1'b0;
            r_pass.vld <= 1'b0;
        end else if (i_drain) begin
            r_hold     <= i_nbr;
            r_pass.vld <= 1'b0;
        end else if (i_ins.vld) begin
            if (!r_hold.vld) begin
                r_hold     <= i_ins;
                r_pass.vld <= 1'b0;
            end else if (i_ins.val < r_hold.val) begin
                r_hold.val <= i_ins.val;
                r_pass     <= r_hold;
            end else begin
                r_pass     <= i_ins;
            end
        end else begin
            r_pass.vld <= 1'b0;
        end
    end

    assign o_hold = r_hold;
    assign o_pass = r_pass;

endmodule

`default_nettype wire

>>> src/lmads_chain.sv
`default_nettype none

module lmads_chain #(
    parameter int MAX_POINTS = lmads_pkg::MAX_POINTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_drain,
    input  wire lmads_pkg::t_slot i_ins,
    output lmads_pkg::t_slot      o_head,
    output logic                  o_spill
);

    lmads_pkg::t_slot w_hold [MAX_POINTS];
    lmads_pkg::t_slot w_pass [MAX_POINTS];

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        lmads_pkg::t_slot w_ins;
        lmads_pkg::t_slot w_nbr;

        if (g == 0) begin : g_first
            assign w_ins = i_ins;
        end else begin : g_mid
            assign w_ins = w_pass[g-1];
        end

        if (g == MAX_POINTS - 1) begin : g_end
            assign w_nbr = '0;
        end else begin : g_inner
            assign w_nbr = w_hold[g+1];
        end

        lmads_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_drain (i_drain),
            .i_ins   (w_ins),
            .i_nbr   (w_nbr),
            .o_hold  (w_hold[g]),
            .o_pass  (w_pass[g])
        );
    end

    assign o_head  = w_hold[0];
    assign o_spill = w_pass[MAX_POINTS-1].vld;

endmodule

`default_nettype wire
